FILE: rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: beat payload types, status and
// mode codes, and the sequencer state type. Depends on nothing.
package ffha_pkg;

    localparam logic       MODE_ALLOC   = 1'b0;
    localparam logic       MODE_FREE    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NOFIT = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_size;
        logic [31:0] body_address;
    } req_t;

    typedef struct packed {
        logic [31:0] address;
        logic [1:0]  status;
        logic [14:0] used_bytes;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_A_WPOS,
        ST_F_RD,
        ST_F_CHK,
        ST_F_NRD,
        ST_F_NCHK,
        ST_F_PRD,
        ST_F_PCHK,
        ST_F_DROP,
        ST_F_WPOS,
        ST_L_RD,
        ST_L_WR,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/ffha_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ffha_ctrl.sv
// Sequencer and datapath of the allocator: walks block headers held in the
// header RAM one access per cycle. Depends on ffha_pkg and ffha_ram.
module ffha_ctrl #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   heap_base,
    input  ffha_pkg::req_t req,
    input  logic          req_valid,
    output logic          req_stall,
    output ffha_pkg::rsp_t res,
    output logic          res_valid,
    input  logic          res_take
);
    import ffha_pkg::*;

    localparam int NGRAN = HEAP_BYTES / 4;
    localparam int GW    = $clog2(NGRAN);
    localparam int HDR   = ((HEADER_BYTES + 3) / 4) * 4;
    localparam int BW    = $clog2(HEAP_BYTES + 1);
    localparam int EW    = GW + BW + 3;

    localparam logic [GW:0]   NGRAN_W   = (GW + 1)'(NGRAN);
    localparam logic [BW-1:0] HDR_W     = BW'(HDR);
    localparam logic [BW-1:0] INIT_BODY = BW'(NGRAN * 4 - HDR);
    localparam logic [31:0]   HEAP_LEN  = 32'(NGRAN * 4);

    function automatic logic [EW-1:0] pack_ent(logic s, logic f, logic [BW-1:0] b,
                                               logic [GW-1:0] p, logic v);
        return {s, f, b, p, v};
    endfunction

    function automatic logic [GW:0] next_of(logic [GW-1:0] p, logic [BW-1:0] b);
        logic [BW:0] span;
        span = {1'b0, b} + (BW + 1)'(HDR);
        return {1'b0, p} + (GW + 1)'(span >> 2);
    endfunction

    state_t        state_reg, state_next, ret_reg;
    logic [GW-1:0] clr_reg;
    logic [GW:0]   pos_reg;
    logic [16:0]   size_reg;
    logic [BW-1:0] ent_body_reg;
    logic [GW-1:0] ent_prev_reg;
    logic          ent_pv_reg;
    logic [BW-1:0] aux_body_reg;
    logic [GW:0]   tgt_reg;
    logic [GW-1:0] prv_reg;
    logic [BW-1:0] used_reg;
    logic [31:0]   res_addr_reg;
    logic [1:0]    res_status_reg;

    logic          ram_en, ram_we;
    logic [GW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, rd_data;

    logic          rd_start, rd_free, rd_pv;
    logic [BW-1:0] rd_body;
    logic [GW-1:0] rd_prev;

    logic [16:0]   size_in;
    logic [31:0]   off;
    logic          off_ok;
    logic          fits, split;
    logic [BW-1:0] frag, sum_body;
    logic [GW-1:0] pos_g, np;
    logic [GW:0]   nx_rd, nx_pos_new, nx_pv_new;
    logic [31:0]   used32;

    ffha_ram #(.WIDTH(EW), .DEPTH(NGRAN)) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd_data)
    );

    assign rd_start = rd_data[EW-1];
    assign rd_free  = rd_data[EW-2];
    assign rd_body  = rd_data[EW-3 -: BW];
    assign rd_prev  = rd_data[GW:1];
    assign rd_pv    = rd_data[0];

    assign pos_g      = pos_reg[GW-1:0];
    assign size_in    = ({1'b0, req.request_size} + 17'd3) & ~17'd3;
    assign off        = req.body_address - heap_base - 32'(HDR);
    assign off_ok     = (off[1:0] == 2'b00) && (off < HEAP_LEN);
    assign fits       = rd_free && (32'(rd_body) >= 32'(size_reg));
    assign frag       = rd_body - BW'(size_reg);
    assign split      = frag > HDR_W;
    assign np         = pos_g + GW'((32'(size_reg) + 32'(HDR)) >> 2);
    assign nx_rd      = next_of(pos_g, rd_body);
    assign sum_body   = ent_body_reg + rd_body + HDR_W;
    assign nx_pos_new = next_of(pos_g, sum_body);
    assign nx_pv_new  = next_of(ent_prev_reg, sum_body);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == GW'(NGRAN - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.mode == MODE_ALLOC)
                        state_next = ST_A_RD;
                    else if (off_ok)
                        state_next = ST_F_RD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_A_RD:    state_next = (pos_reg >= NGRAN_W) ? ST_DONE : ST_A_CHK;
            ST_A_CHK:
            begin
                if (!rd_start)
                    state_next = ST_DONE;
                else if (fits)
                    state_next = split ? ST_A_SPLIT : ST_A_WPOS;
                else
                    state_next = ST_A_RD;
            end
            ST_A_SPLIT: state_next = (tgt_reg < NGRAN_W) ? ST_L_RD : ST_A_WPOS;
            ST_A_WPOS:  state_next = ST_DONE;
            ST_L_RD:    state_next = ST_L_WR;
            ST_L_WR:    state_next = ret_reg;
            ST_F_RD:    state_next = ST_F_CHK;
            ST_F_CHK:
            begin
                if (!rd_start || rd_free)
                    state_next = ST_DONE;
                else
                    state_next = (nx_rd < NGRAN_W) ? ST_F_NRD : ST_F_PRD;
            end
            ST_F_NRD:   state_next = ST_F_NCHK;
            ST_F_NCHK:
            begin
                if (rd_free && (nx_pos_new < NGRAN_W))
                    state_next = ST_L_RD;
                else
                    state_next = ST_F_PRD;
            end
            ST_F_PRD:   state_next = ent_pv_reg ? ST_F_PCHK : ST_F_WPOS;
            ST_F_PCHK:  state_next = rd_free ? ST_F_DROP : ST_F_WPOS;
            ST_F_DROP:  state_next = (tgt_reg < NGRAN_W) ? ST_L_RD : ST_DONE;
            ST_F_WPOS:  state_next = ST_DONE;
            ST_DONE:    if (res_take) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Header RAM access for each state.
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = pos_g;
        ram_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                if (clr_reg == '0)
                    ram_wdata = pack_ent(1'b1, 1'b1, INIT_BODY, '0, 1'b0);
            end
            ST_A_RD:    ram_en = pos_reg < NGRAN_W;
            ST_A_SPLIT:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = prv_reg;
                ram_wdata = pack_ent(1'b1, 1'b1, aux_body_reg, pos_g, 1'b1);
            end
            ST_A_WPOS:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = pack_ent(1'b1, 1'b0, ent_body_reg, ent_prev_reg, ent_pv_reg);
            end
            ST_L_RD:
            begin
                ram_en   = 1'b1;
                ram_addr = tgt_reg[GW-1:0];
            end
            ST_L_WR:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = tgt_reg[GW-1:0];
                ram_wdata = pack_ent(rd_start, rd_free, rd_body, prv_reg, 1'b1);
            end
            ST_F_RD:    ram_en = 1'b1;
            ST_F_NRD:
            begin
                ram_en   = 1'b1;
                ram_addr = tgt_reg[GW-1:0];
            end
            ST_F_NCHK:
            begin
                // An absorbed header is wiped so it no longer counts as a block.
                ram_en   = rd_free;
                ram_we   = rd_free;
                ram_addr = tgt_reg[GW-1:0];
            end
            ST_F_PRD:
            begin
                ram_en   = ent_pv_reg;
                ram_addr = ent_prev_reg;
            end
            ST_F_PCHK:
            begin
                ram_en    = rd_free;
                ram_we    = rd_free;
                ram_addr  = ent_prev_reg;
                ram_wdata = pack_ent(1'b1, 1'b1, sum_body, rd_prev, rd_pv);
            end
            ST_F_DROP:
            begin
                ram_en = 1'b1;
                ram_we = 1'b1;
            end
            ST_F_WPOS:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = pack_ent(1'b1, 1'b1, ent_body_reg, ent_prev_reg, ent_pv_reg);
            end
            ST_IDLE, ST_A_CHK, ST_F_CHK, ST_DONE: ram_en = 1'b0;
            default:    ram_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + GW'(1);
            if (state_reg == ST_A_WPOS)
                used_reg <= used_reg + ent_body_reg + HDR_W;
            else if (state_reg == ST_F_CHK && rd_start && !rd_free)
                used_reg <= used_reg - rd_body - HDR_W;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                size_reg       <= size_in;
                pos_reg        <= (req.mode == MODE_ALLOC) ? '0 : {1'b0, off[GW+1:2]};
                res_addr_reg   <= '0;
                res_status_reg <= STATUS_BAD;
            end
            ST_A_RD:
            begin
                if (pos_reg >= NGRAN_W)
                    res_status_reg <= STATUS_NOFIT;
            end
            ST_A_CHK:
            begin
                res_status_reg <= STATUS_NOFIT;
                ent_prev_reg   <= rd_prev;
                ent_pv_reg     <= rd_pv;
                ent_body_reg   <= split ? BW'(size_reg) : rd_body;
                aux_body_reg   <= frag - HDR_W;
                prv_reg        <= np;
                tgt_reg        <= nx_rd;
                ret_reg        <= ST_A_WPOS;
                if (!fits)
                    pos_reg <= nx_rd;
            end
            ST_A_WPOS:
            begin
                res_status_reg <= STATUS_OK;
                res_addr_reg   <= heap_base + 32'({pos_g, 2'b00}) + 32'(HDR);
            end
            ST_F_CHK:
            begin
                if (rd_start && !rd_free)
                    res_status_reg <= STATUS_OK;
                ent_body_reg <= rd_body;
                ent_prev_reg <= rd_prev;
                ent_pv_reg   <= rd_pv;
                tgt_reg      <= nx_rd;
            end
            ST_F_NCHK:
            begin
                if (rd_free)
                begin
                    ent_body_reg <= sum_body;
                    tgt_reg      <= nx_pos_new;
                    prv_reg      <= pos_g;
                    ret_reg      <= ST_F_PRD;
                end
            end
            ST_F_PCHK:
            begin
                tgt_reg <= nx_pv_new;
                prv_reg <= ent_prev_reg;
                ret_reg <= ST_DONE;
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    assign used32    = 32'(used_reg);
    assign req_stall = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = '{address: res_addr_reg, status: res_status_reg,
                         used_bytes: used32[14:0]};

`ifndef ASSERT_OFF
    a_idle_no_ram: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_en)
        else $error("header RAM accessed while idle");
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status_reg != STATUS_OK |-> res_addr_reg == '0)
        else $error("failed beat carries an address");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= HEAP_LEN)
        else $error("used total exceeds heap");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_take |=> res_valid && $stable(res_status_reg))
        else $error("result left before it was taken");
`endif

endmodule

FILE: rtl/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator: base register, output register
// and the sequencer. Depends on ffha_pkg and ffha_ctrl.
//
// Usage. A request beat on req (req_valid/req_stall) either allocates
// request_size bytes (mode 0) or frees the block whose body starts at
// body_address (mode 1). Each request gives exactly one beat on rsp
// (rsp_valid/rsp_stall) with the body address, a status and the used-byte
// total. cfg_we writes heap_base, rounded up to a multiple of four.
// Timing. All header state lives in a single-port RAM, one access a cycle.
// An allocate walks the block headers up to the fitting one and takes longer
// when the block is split; a free's length depends on the merges. One request
// is worked on at a time.
// Reset. After reset the RAM is cleared one granule a cycle, while
// req_stall stays high.
// Stalls. The finished beat waits in the output register; a new request is
// taken meanwhile, and its result waits until the held beat is taken.
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES   = 16384,
    parameter int HEADER_BYTES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffha_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffha_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_data
);
    import ffha_pkg::*;

    logic [31:0] heap_base_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;
    rsp_t        res;
    logic        res_valid, res_take;

    assign res_take = !rsp_valid_reg || !rsp_stall;

    ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .heap_base (heap_base_reg),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res       (res),
        .res_valid (res_valid),
        .res_take  (res_take)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                heap_base_reg <= (cfg_data + 32'd3) & ~32'd3;
            if (res_valid && res_take)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            rsp_reg <= res;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
